@@ rtl/core/aqcr_pkg.sv @@
// ----------------------------------------------------------------------------
// aqcr_pkg: shared types and constants of the quarter circle row rasterizer
// Widths of the radius, of the fixed point square root and the sideband
// record that travels with each row through the root pipeline.
// ----------------------------------------------------------------------------
package aqcr_pkg;

   // radius and row width in bits
   localparam int RADIUS_BITS = 10;
   // fraction bits of the root
   localparam int FRAC_BITS   = 16;
   // width of the fixed point root, one pipeline stage per bit
   localparam int ROOT_W      = RADIUS_BITS + FRAC_BITS;
   // width of r*r - y*y
   localparam int DIFF_W      = 2 * RADIUS_BITS;
   // width of the partial remainder
   localparam int REM_W       = ROOT_W + 2;
   // width of the center coordinates and of the result coordinates
   localparam int CENTER_W    = 16;
   localparam int COORD_W     = 17;

   // row fields that ride along with the root computation
   typedef struct packed {
      logic [RADIUS_BITS-1:0]    row;
      logic signed [CENTER_W-1:0] center_x;
      logic signed [CENTER_W-1:0] center_y;
      logic                      x_neg;
      logic                      y_neg;
      logic                      beyond;   // row lies past the radius
   } aqcr_side_type;

endpackage

@@ rtl/core/aqcr_isqrt_pipe.sv @@
// ----------------------------------------------------------------------------
// aqcr_isqrt_pipe: pipelined fixed point square root
// Computes floor(sqrt(d << 2*FRAC_BITS)) one root bit per register stage,
// restoring digit by digit. A new beat may enter every cycle.
// ----------------------------------------------------------------------------
module aqcr_isqrt_pipe (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic [aqcr_pkg::DIFF_W-1:0]         in_diff,
   input  aqcr_pkg::aqcr_side_type             in_side,
   output logic                                out_valid,
   output logic [aqcr_pkg::ROOT_W-1:0]         out_root,
   output aqcr_pkg::aqcr_side_type             out_side
);

   localparam int W  = aqcr_pkg::ROOT_W;
   localparam int RW = aqcr_pkg::REM_W;
   localparam int DW = aqcr_pkg::DIFF_W;
   localparam int FB = aqcr_pkg::FRAC_BITS;
   // last stage that still reads radicand bits
   localparam int DL = W - 1 - FB;

   // stage registers; index k holds a beat after k root bits
   logic                    valid_ff [1:W];
   logic [RW-1:0]           rem_ff   [1:W];
   logic [W-1:0]            root_ff  [1:W];
   logic [DW-1:0]           diff_ff  [1:DL];
   aqcr_pkg::aqcr_side_type side_ff  [1:W];

   genvar i;
   generate
      for (i = 0; i < W; i++) begin : g_stage
         localparam int P = W - 1 - i;   // radicand bit pair consumed here
         logic                    valid_cur;
         logic [RW-1:0]           rem_cur;
         logic [W-1:0]            root_cur;
         aqcr_pkg::aqcr_side_type side_cur;
         logic [1:0]              pair;
         logic [RW+1:0]           rem_sh;
         logic [RW+1:0]           trial;
         logic                    take;
         logic [RW+1:0]           rem_sub;
         logic [RW-1:0]           rem_in;
         logic [W-1:0]            root_in;

         // select the stage inputs; the first stage starts from zero
         if (i == 0) begin : g_first
            assign valid_cur = in_valid;
            assign rem_cur   = '0;
            assign root_cur  = '0;
            assign side_cur  = in_side;
         end else begin : g_next
            assign valid_cur = valid_ff[i];
            assign rem_cur   = rem_ff[i];
            assign root_cur  = root_ff[i];
            assign side_cur  = side_ff[i];
         end

         // pick the next two radicand bits; the low 2*FRAC_BITS are zero
         if (P >= FB) begin : g_data
            if (i == 0) begin : g_first
               assign pair = in_diff[2*(P-FB)+1 -: 2];
            end else begin : g_next
               assign pair = diff_ff[i][2*(P-FB)+1 -: 2];
            end
         end else begin : g_zero
            assign pair = 2'b00;
         end

         // carry the radicand while later stages still read it
         if (P > FB) begin : g_carry
            if (i == 0) begin : g_first
               always_ff @(posedge clock) begin
                  diff_ff[i+1] <= in_diff;
               end
            end else begin : g_next
               always_ff @(posedge clock) begin
                  diff_ff[i+1] <= diff_ff[i];
               end
            end
         end

         // try to set the next root bit
         always_comb begin
            rem_sh  = {rem_cur, pair};
            trial   = {2'b00, root_cur, 2'b01};
            take    = (rem_sh >= trial);
            rem_sub = take ? (rem_sh - trial) : rem_sh;
            rem_in  = rem_sub[RW-1:0];
            root_in = {root_cur[W-2:0], take};
         end

         // advance the valid bit
         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[i+1] <= 1'b0;
            end else begin
               valid_ff[i+1] <= valid_cur;
            end
         end

         // advance the payload
         always_ff @(posedge clock) begin
            rem_ff[i+1]  <= rem_in;
            root_ff[i+1] <= root_in;
            side_ff[i+1] <= side_cur;
         end
      end
   endgenerate

   assign out_valid = valid_ff[W];
   assign out_root  = root_ff[W];
   assign out_side  = side_ff[W];

endmodule

@@ rtl/core/aa_quarter_circle_row_rasterizer_unit.sv @@
// ----------------------------------------------------------------------------
// aa_quarter_circle_row_rasterizer_unit: antialiased quarter circle rows
// The path from start to rsp_strobe runs through the input register, the
// r*r - y*y register, one stage per root bit and then the output register.
// Throughput: one row per cycle; busy stays low, the root pipeline takes a
// beat every cycle. Synchronous reset clears all valid bits and the strobe;
// payload registers are not reset.
// ----------------------------------------------------------------------------
module aa_quarter_circle_row_rasterizer_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic [aqcr_pkg::RADIUS_BITS-1:0]        req_radius,
   input  logic [aqcr_pkg::RADIUS_BITS-1:0]        req_row,
   input  logic signed [aqcr_pkg::CENTER_W-1:0]    req_center_x,
   input  logic signed [aqcr_pkg::CENTER_W-1:0]    req_center_y,
   input  logic                                    req_x_neg,
   input  logic                                    req_y_neg,
   output logic                                    rsp_strobe,
   output logic                                    rsp_draw,
   output logic signed [aqcr_pkg::COORD_W-1:0]     rsp_row_coord,
   output logic signed [aqcr_pkg::COORD_W-1:0]     rsp_col_coord,
   output logic signed [aqcr_pkg::COORD_W-1:0]     rsp_span_x_end,
   output logic signed [aqcr_pkg::COORD_W-1:0]     rsp_span_y_end,
   output logic signed [aqcr_pkg::COORD_W-1:0]     rsp_edge_x,
   output logic signed [aqcr_pkg::COORD_W-1:0]     rsp_edge_y,
   output logic [7:0]                              rsp_alpha
);

   localparam int RB = aqcr_pkg::RADIUS_BITS;
   localparam int FB = aqcr_pkg::FRAC_BITS;
   localparam int W  = aqcr_pkg::ROOT_W;
   localparam int DW = aqcr_pkg::DIFF_W;
   localparam int CW = aqcr_pkg::COORD_W;
   localparam int NW = aqcr_pkg::CENTER_W;

   // center plus or minus a magnitude, wrapped to the coordinate width
   function automatic logic [CW-1:0] coord_of(input logic signed [NW-1:0] base,
                                               input logic neg,
                                               input logic [RB:0] mag);
      logic [CW-1:0] b;
      logic [CW-1:0] m;
      b = {{(CW-NW){base[NW-1]}}, base};
      m = {{(CW-RB-1){1'b0}}, mag};
      return neg ? (b - m) : (b + m);
   endfunction

   logic accept;

   // input register
   logic                    in_valid_ff;
   logic [RB-1:0]           in_radius_ff;
   aqcr_pkg::aqcr_side_type in_side_ff;

   // square root entry
   logic                    sq_valid_ff;
   logic [DW-1:0]           sq_diff_ff;
   aqcr_pkg::aqcr_side_type sq_side_ff;
   logic [DW-1:0]           sq_diff_in;
   aqcr_pkg::aqcr_side_type sq_side_in;
   logic [RB-1:0]           gap;
   logic [RB:0]             sum;
   logic [DW-1:0]           prod;

   // root pipeline result
   logic                    rt_valid;
   logic [W-1:0]            rt_root;
   aqcr_pkg::aqcr_side_type rt_side;

   // final stage
   logic [RB-1:0]           fl;
   logic [FB-1:0]           frac;
   logic [RB:0]             fl_ext;
   logic [RB:0]             fl_inc;
   logic [RB:0]             row_ext;
   logic [FB+7:0]           scaled;
   logic                    draw_in;

   logic                    strobe_ff;
   logic                    draw_ff;
   logic [CW-1:0]           row_coord_ff, row_coord_in;
   logic [CW-1:0]           col_coord_ff, col_coord_in;
   logic [CW-1:0]           span_x_ff, span_x_in;
   logic [CW-1:0]           span_y_ff, span_y_in;
   logic [CW-1:0]           edge_x_ff, edge_x_in;
   logic [CW-1:0]           edge_y_ff, edge_y_in;
   logic [7:0]              alpha_ff, alpha_in;

   // the pipeline never stalls
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // capture the request beat
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      in_radius_ff        <= req_radius;
      in_side_ff.row      <= req_row;
      in_side_ff.center_x <= req_center_x;
      in_side_ff.center_y <= req_center_y;
      in_side_ff.x_neg    <= req_x_neg;
      in_side_ff.y_neg    <= req_y_neg;
      in_side_ff.beyond   <= (req_row > req_radius);
   end

   // form r*r - y*y as (r - y) * (r + y); zero when the row is past the radius
   always_comb begin
      gap        = in_radius_ff - in_side_ff.row;
      sum        = {1'b0, in_radius_ff} + {1'b0, in_side_ff.row};
      prod       = {{RB{1'b0}}, gap} * {{(RB-1){1'b0}}, sum};
      sq_diff_in = in_side_ff.beyond ? '0 : prod;
      sq_side_in = in_side_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else begin
         sq_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      sq_diff_ff <= sq_diff_in;
      sq_side_ff <= sq_side_in;
   end

   aqcr_isqrt_pipe u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid_ff),
      .in_diff   (sq_diff_ff),
      .in_side   (sq_side_ff),
      .out_valid (rt_valid),
      .out_root  (rt_root),
      .out_side  (rt_side)
   );

   // split the root, test for the end of the arc, place the spans
   always_comb begin
      fl       = rt_root[W-1:FB];
      frac     = rt_root[FB-1:0];
      fl_ext   = {1'b0, fl};
      fl_inc   = fl_ext + {{RB{1'b0}}, 1'b1};
      row_ext  = {1'b0, rt_side.row};
      scaled   = {frac, 8'd0} - {8'd0, frac};
      draw_in  = !rt_side.beyond && !((fl_ext + (RB+1)'(2)) < row_ext);
      row_coord_in = '0;
      col_coord_in = '0;
      span_x_in    = '0;
      span_y_in    = '0;
      edge_x_in    = '0;
      edge_y_in    = '0;
      alpha_in     = '0;
      if (draw_in) begin
         row_coord_in = coord_of(rt_side.center_y, rt_side.y_neg, row_ext);
         col_coord_in = coord_of(rt_side.center_x, rt_side.x_neg, row_ext);
         span_x_in    = coord_of(rt_side.center_x, rt_side.x_neg, fl_ext);
         span_y_in    = coord_of(rt_side.center_y, rt_side.y_neg, fl_ext);
         edge_x_in    = coord_of(rt_side.center_x, rt_side.x_neg, fl_inc);
         edge_y_in    = coord_of(rt_side.center_y, rt_side.y_neg, fl_inc);
         alpha_in     = scaled[FB+7:FB];
      end
   end

   // drive the result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= rt_valid;
      end
   end

   always_ff @(posedge clock) begin
      draw_ff      <= draw_in;
      row_coord_ff <= row_coord_in;
      col_coord_ff <= col_coord_in;
      span_x_ff    <= span_x_in;
      span_y_ff    <= span_y_in;
      edge_x_ff    <= edge_x_in;
      edge_y_ff    <= edge_y_in;
      alpha_ff     <= alpha_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_draw       = draw_ff;
   assign rsp_row_coord  = row_coord_ff;
   assign rsp_col_coord  = col_coord_ff;
   assign rsp_span_x_end = span_x_ff;
   assign rsp_span_y_end = span_y_ff;
   assign rsp_edge_x     = edge_x_ff;
   assign rsp_edge_y     = edge_y_ff;
   assign rsp_alpha      = alpha_ff;

`ifndef SYNTHESIS
   // a row that ends the arc carries no coordinates
   a_end_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_draw) |-> (rsp_row_coord == '0 && rsp_col_coord == '0 &&
         rsp_span_x_end == '0 && rsp_span_y_end == '0 && rsp_edge_x == '0 &&
         rsp_edge_y == '0 && rsp_alpha == '0))
      else $error("terminating row carries nonzero fields");

   // the edge column sits one pixel beyond the horizontal span end
   a_edge_x_next: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_draw) |-> ((rsp_edge_x - rsp_span_x_end) == 17'sd1 ||
         (rsp_span_x_end - rsp_edge_x) == 17'sd1))
      else $error("edge column not adjacent to span end");

   // the mirrored edge row sits one pixel beyond the vertical span end
   a_edge_y_next: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_draw) |-> ((rsp_edge_y - rsp_span_y_end) == 17'sd1 ||
         (rsp_span_y_end - rsp_edge_y) == 17'sd1))
      else $error("edge row not adjacent to span end");
`endif

endmodule
